/* design/xcrc_pkg.sv */
// Shared types, codes and the CRC-16 byte step for the XMODEM-CRC sector receiver.
package xcrc_pkg;

   // Input item: operation code and received byte.
   typedef struct packed {
      logic [1:0] op;
      logic [7:0] rx_byte;
   } req_type;

   // One result beat.
   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] value;
      logic       long_block;
      logic       last;
   } rsp_type;

   // Every result beat that one input item causes, oldest in slot 0.
   localparam int unsigned MaxResults = 3;
   typedef struct packed {
      logic [1:0]                   count;
      rsp_type [MaxResults-1:0]     slot;
   } bundle_type;

   // Depth of the queue between the protocol engine and the result side.
   localparam int unsigned QueueDepth = 4;
   localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

   // Operation codes.
   localparam logic [1:0] OP_BYTE    = 2'd0;
   localparam logic [1:0] OP_TIMEOUT = 2'd1;
   localparam logic [1:0] OP_START   = 2'd2;

   // Result kinds.
   localparam logic [2:0] KIND_DATA    = 3'd0;
   localparam logic [2:0] KIND_COMMIT  = 3'd1;
   localparam logic [2:0] KIND_DISCARD = 3'd2;
   localparam logic [2:0] KIND_TX      = 3'd3;
   localparam logic [2:0] KIND_DONE    = 3'd4;
   localparam logic [2:0] KIND_ABORT   = 3'd5;

   // Abort causes.
   localparam logic [7:0] CAUSE_CANCEL  = 8'd0;
   localparam logic [7:0] CAUSE_RETRIES = 8'd1;
   localparam logic [7:0] CAUSE_SYNC    = 8'd2;

   // Line characters.
   localparam logic [7:0] CH_SOH = 8'h01;
   localparam logic [7:0] CH_STX = 8'h02;
   localparam logic [7:0] CH_EOT = 8'h04;
   localparam logic [7:0] CH_ACK = 8'h06;
   localparam logic [7:0] CH_NAK = 8'h15;
   localparam logic [7:0] CH_CAN = 8'h18;
   localparam logic [7:0] CH_C   = 8'h43;

   // Sector sizes and the block number check sum.
   localparam logic [10:0] LEN_SHORT  = 11'd128;
   localparam logic [10:0] LEN_LONG   = 11'd1024;
   localparam logic [8:0]  NUM_CHECK  = 9'h0FF;

   // Retry limit after reset.
   localparam logic [3:0]  RETRY_LIMIT_RESET = 4'd10;

   // CRC-16 with polynomial 0x1021, one byte, most significant bit first.
   function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {data, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ 16'h1021;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

   // Appends one result beat to a bundle; a full bundle stays as it is.
   function automatic bundle_type bundle_add(bundle_type b, logic [2:0] kind,
                                             logic [7:0] value, logic lng);
      bundle_type r;
      r = b;
      if (r.count != 2'(MaxResults)) begin
         r.slot[r.count].kind       = kind;
         r.slot[r.count].value      = value;
         r.slot[r.count].long_block = lng;
         r.slot[r.count].last       = 1'b0;
         r.count                    = r.count + 2'd1;
      end
      return r;
   endfunction

endpackage

/* design/xcrc_front.sv */
// Protocol engine: takes one input beat a cycle while accept is high, and builds its bundle of results.
module xcrc_front #(
   parameter int unsigned PURGE_MAX = 1000
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [3:0]           csr_wr_data,
   input  logic                 accept,
   input  xcrc_pkg::req_type    req,
   output logic                 bundle_push,
   output xcrc_pkg::bundle_type bundle
);

   // Receiver phases.
   localparam logic [3:0] PH_IDLE  = 4'd0;
   localparam logic [3:0] PH_HDR   = 4'd1;
   localparam logic [3:0] PH_NUM   = 4'd2;
   localparam logic [3:0] PH_CMP   = 4'd3;
   localparam logic [3:0] PH_DATA  = 4'd4;
   localparam logic [3:0] PH_CRC1  = 4'd5;
   localparam logic [3:0] PH_CRC2  = 4'd6;
   localparam logic [3:0] PH_EOTW  = 4'd7;
   localparam logic [3:0] PH_PURGE = 4'd8;
   localparam logic [3:0] PH_DONE  = 4'd9;
   localparam logic [3:0] PH_ABORT = 4'd10;

   localparam logic [9:0] PurgeLimit = 10'(PURGE_MAX);

   logic [3:0]  retry_limit_ff;
   logic [3:0]  phase_ff, phase_in;
   logic [7:0]  expected_ff, expected_in;
   logic [7:0]  got_ff, got_in;
   logic [15:0] crc_ff, crc_in;
   logic [10:0] byte_count_ff, byte_count_in;
   logic        block_long_ff, block_long_in;
   logic        first_ff, first_in;
   logic [3:0]  retry_ff, retry_in;
   logic        cancel_ff, cancel_in;
   logic [9:0]  purge_ff, purge_in;

   logic        end_purge;
   logic        count_err;
   logic [3:0]  retry_inc;
   logic [9:0]  purge_inc;
   logic [10:0] byte_inc;
   logic [15:0] crc_next;

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         retry_limit_ff <= xcrc_pkg::RETRY_LIMIT_RESET;
      end else if (csr_wr_en) begin
         retry_limit_ff <= csr_wr_data;
      end
   end

   assign retry_inc = retry_ff + 4'd1;
   assign purge_inc = purge_ff + 10'd1;
   assign byte_inc  = byte_count_ff + 11'd1;
   assign crc_next  = xcrc_pkg::crc16_byte(crc_ff, req.rx_byte);

   // Next state and result bundle for the item on the input.
   always_comb begin
      phase_in      = phase_ff;
      expected_in   = expected_ff;
      got_in        = got_ff;
      crc_in        = crc_ff;
      byte_count_in = byte_count_ff;
      block_long_in = block_long_ff;
      first_in      = first_ff;
      retry_in      = retry_ff;
      cancel_in     = cancel_ff;
      purge_in      = purge_ff;
      end_purge     = 1'b0;
      count_err     = 1'b0;
      bundle        = '0;

      if (req.op == xcrc_pkg::OP_START) begin
         phase_in      = PH_HDR;
         expected_in   = 8'd0;
         got_in        = 8'd0;
         crc_in        = 16'd0;
         byte_count_in = 11'd0;
         block_long_in = 1'b0;
         first_in      = 1'b1;
         retry_in      = 4'd0;
         cancel_in     = 1'b0;
         purge_in      = 10'd0;
         bundle = xcrc_pkg::bundle_add(bundle, xcrc_pkg::KIND_TX, xcrc_pkg::CH_C, 1'b0);
      end else if (req.op == xcrc_pkg::OP_BYTE) begin
         case (phase_ff)
            PH_HDR: begin
               if (req.rx_byte == xcrc_pkg::CH_STX || req.rx_byte == xcrc_pkg::CH_SOH) begin
                  block_long_in = (req.rx_byte == xcrc_pkg::CH_STX);
                  phase_in      = PH_NUM;
               end else if (req.rx_byte == xcrc_pkg::CH_EOT) begin
                  phase_in = PH_EOTW;
               end else if (req.rx_byte == xcrc_pkg::CH_CAN) begin
                  if (cancel_ff) begin
                     bundle = xcrc_pkg::bundle_add(bundle, xcrc_pkg::KIND_ABORT,
                                                   xcrc_pkg::CAUSE_CANCEL, 1'b0);
                     phase_in = PH_ABORT;
                  end else begin
                     cancel_in = 1'b1;
                     count_err = 1'b1;
                  end
               end else begin
                  cancel_in = 1'b0;
                  purge_in  = 10'd0;
                  phase_in  = PH_PURGE;
               end
            end
            PH_NUM: begin
               got_in   = req.rx_byte;
               phase_in = PH_CMP;
            end
            PH_CMP: begin
               if ({1'b0, got_ff} + {1'b0, req.rx_byte} == xcrc_pkg::NUM_CHECK) begin
                  crc_in        = 16'd0;
                  byte_count_in = 11'd0;
                  phase_in      = PH_DATA;
               end else begin
                  cancel_in = 1'b0;
                  purge_in  = 10'd0;
                  phase_in  = PH_PURGE;
               end
            end
            PH_DATA: begin
               crc_in        = crc_next;
               byte_count_in = byte_inc;
               bundle = xcrc_pkg::bundle_add(bundle, xcrc_pkg::KIND_DATA, req.rx_byte, 1'b0);
               if (byte_inc >= (block_long_ff ? xcrc_pkg::LEN_LONG : xcrc_pkg::LEN_SHORT)) begin
                  phase_in = PH_CRC1;
               end
            end
            PH_CRC1: begin
               crc_in   = crc_next;
               phase_in = PH_CRC2;
            end
            PH_CRC2: begin
               crc_in = crc_next;
               if (crc_next != 16'd0) begin
                  bundle = xcrc_pkg::bundle_add(bundle, xcrc_pkg::KIND_DISCARD, got_ff, 1'b0);
                  cancel_in = 1'b0;
                  purge_in  = 10'd0;
                  phase_in  = PH_PURGE;
               end else begin
                  first_in = 1'b0;
                  if (got_ff == expected_ff + 8'd1 || got_ff == expected_ff) begin
                     if (got_ff == expected_ff + 8'd1) begin
                        expected_in = expected_ff + 8'd1;
                        bundle = xcrc_pkg::bundle_add(bundle, xcrc_pkg::KIND_COMMIT, got_ff,
                                                      block_long_ff);
                     end else begin
                        bundle = xcrc_pkg::bundle_add(bundle, xcrc_pkg::KIND_DISCARD, got_ff,
                                                      1'b0);
                     end
                     bundle = xcrc_pkg::bundle_add(bundle, xcrc_pkg::KIND_TX,
                                                   xcrc_pkg::CH_ACK, 1'b0);
                     retry_in  = 4'd0;
                     cancel_in = 1'b0;
                     phase_in  = PH_HDR;
                  end else begin
                     bundle = xcrc_pkg::bundle_add(bundle, xcrc_pkg::KIND_DISCARD, got_ff, 1'b0);
                     bundle = xcrc_pkg::bundle_add(bundle, xcrc_pkg::KIND_ABORT,
                                                   xcrc_pkg::CAUSE_SYNC, 1'b0);
                     phase_in = PH_ABORT;
                  end
               end
            end
            PH_EOTW: begin
               cancel_in = 1'b0;
               purge_in  = 10'd0;
               phase_in  = PH_PURGE;
            end
            PH_PURGE: begin
               purge_in = purge_inc;
               if (purge_inc >= PurgeLimit || purge_inc == 10'd0) begin
                  end_purge = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end else if (req.op == xcrc_pkg::OP_TIMEOUT) begin
         case (phase_ff)
            PH_HDR, PH_NUM, PH_CMP, PH_DATA, PH_CRC1, PH_CRC2: begin
               if (phase_ff == PH_DATA || phase_ff == PH_CRC1 || phase_ff == PH_CRC2) begin
                  bundle = xcrc_pkg::bundle_add(bundle, xcrc_pkg::KIND_DISCARD, got_ff, 1'b0);
               end
               cancel_in = 1'b0;
               purge_in  = 10'd0;
               end_purge = 1'b1;
            end
            PH_EOTW: begin
               bundle = xcrc_pkg::bundle_add(bundle, xcrc_pkg::KIND_TX, xcrc_pkg::CH_ACK, 1'b0);
               bundle = xcrc_pkg::bundle_add(bundle, xcrc_pkg::KIND_DONE, 8'd0, 1'b0);
               phase_in = PH_DONE;
            end
            PH_PURGE: begin
               end_purge = 1'b1;
            end
            default: begin
            end
         endcase
      end

      // End of a purge: ask for the sector again.
      if (end_purge) begin
         bundle = xcrc_pkg::bundle_add(bundle, xcrc_pkg::KIND_TX,
                                       first_ff ? xcrc_pkg::CH_C : xcrc_pkg::CH_NAK, 1'b0);
      end

      // Count the error; a limit of zero gives up on the first one.
      if (end_purge || count_err) begin
         retry_in = retry_inc;
         if (retry_inc >= retry_limit_ff || retry_inc == 4'd0) begin
            bundle = xcrc_pkg::bundle_add(bundle, xcrc_pkg::KIND_ABORT,
                                          xcrc_pkg::CAUSE_RETRIES, 1'b0);
            phase_in = PH_ABORT;
         end else begin
            phase_in = PH_HDR;
         end
      end
   end

   assign bundle_push = accept && (bundle.count != 2'd0);

   // Protocol state advances on every accepted beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         expected_ff   <= 8'd0;
         got_ff        <= 8'd0;
         crc_ff        <= 16'd0;
         byte_count_ff <= 11'd0;
         block_long_ff <= 1'b0;
         first_ff      <= 1'b1;
         retry_ff      <= 4'd0;
         cancel_ff     <= 1'b0;
         purge_ff      <= 10'd0;
      end else if (accept) begin
         phase_ff      <= phase_in;
         expected_ff   <= expected_in;
         got_ff        <= got_in;
         crc_ff        <= crc_in;
         byte_count_ff <= byte_count_in;
         block_long_ff <= block_long_in;
         first_ff      <= first_in;
         retry_ff      <= retry_in;
         cancel_ff     <= cancel_in;
         purge_ff      <= purge_in;
      end
   end

endmodule

/* design/xcrc_queue.sv */
// Short queue of result bundles between the protocol engine and the result side.
module xcrc_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  xcrc_pkg::bundle_type push_data,
   output logic                 full,
   input  logic                 pop,
   output xcrc_pkg::bundle_type head,
   output logic                 empty
);

   localparam int unsigned PtrW   = xcrc_pkg::QueuePtrW;
   localparam int unsigned CountW = PtrW + 1;

   xcrc_pkg::bundle_type entry_ff [xcrc_pkg::QueueDepth];
   logic [PtrW-1:0]                wr_ptr_ff, rd_ptr_ff;
   logic [CountW-1:0]              count_ff, count_in;

   assign full  = (count_ff == CountW'(xcrc_pkg::QueueDepth));
   assign empty = (count_ff == '0);
   assign head  = entry_ff[rd_ptr_ff];

   // Occupancy follows pushes and pops.
   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CountW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CountW'(1);
      end
   end

   // Storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Pointers and occupancy.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PtrW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PtrW'(1);
         end
         count_ff <= count_in;
      end
   end

endmodule

/* design/xcrc_back.sv */
// Result side: hands out the beats of the oldest bundle one at a time.
module xcrc_back (
   input  logic                 clock,
   input  logic                 reset,
   input  xcrc_pkg::bundle_type head,
   input  logic                 head_empty,
   output logic                 head_pop,
   output xcrc_pkg::rsp_type    rsp_data,
   output logic                 rsp_empty,
   input  logic                 rsp_pop
);

   logic [1:0] idx_ff;
   logic       final_beat;

   assign final_beat = (idx_ff == head.count - 2'd1);
   assign rsp_empty  = head_empty;

   // Current beat; the last one of a bundle carries the marker.
   always_comb begin
      rsp_data      = head.slot[idx_ff];
      rsp_data.last = final_beat;
   end

   assign head_pop = rsp_pop && !head_empty && final_beat;

   // Beat index within the bundle.
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 2'd0;
      end else if (rsp_pop && !head_empty) begin
         idx_ff <= final_beat ? 2'd0 : idx_ff + 2'd1;
      end
   end

endmodule

/* design/xmodem_crc_sector_receiver_core.sv */
// XMODEM-CRC sector receiver: one input beat per cycle while the result queue has room.
// Input beats are taken one per clock whenever full is low; full rises only when
// the four-entry result queue holds four pending bundles. Each input beat causes zero to
// three result beats, which leave at one per clock on pop, so the sustained rate is
// set by the result side. The CRC-16 check is one byte step per cycle while input is accepted.
module xmodem_crc_sector_receiver_core #(
   parameter int unsigned PURGE_MAX = 1000
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [3:0]        csr_wr_data,
   input  logic              push,
   output logic              full,
   input  xcrc_pkg::req_type req_data,
   output logic              empty,
   input  logic              pop,
   output xcrc_pkg::rsp_type rsp_data
);

   xcrc_pkg::bundle_type bundle;
   xcrc_pkg::bundle_type head;
   logic                 bundle_push;
   logic                 head_pop;
   logic                 head_empty;
   logic                 accept;

   assign accept = push && !full;

   // Front: protocol engine.
   xcrc_front #(
      .PURGE_MAX(PURGE_MAX)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .accept      (accept),
      .req         (req_data),
      .bundle_push (bundle_push),
      .bundle      (bundle)
   );

   // Queue between the two sides.
   xcrc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (bundle_push),
      .push_data (bundle),
      .full      (full),
      .pop       (head_pop),
      .head      (head),
      .empty     (head_empty)
   );

   // Back: result beats.
   xcrc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_empty (head_empty),
      .head_pop   (head_pop),
      .rsp_data   (rsp_data),
      .rsp_empty  (empty),
      .rsp_pop    (pop)
   );

endmodule

/* design/xcrc_checker.sv */
// Port checker for the XMODEM-CRC sector receiver, bound to the top level.
module xcrc_checker (
   input logic              clock,
   input logic              reset,
   input logic              full,
   input logic              empty,
   input logic              pop,
   input xcrc_pkg::rsp_type rsp_data
);

   // Reset leaves no result waiting and room for input.
   a_reset_clears: assert property (@(posedge clock) reset |=> (empty && !full))
      else $error("queue not cleared by reset");

   // A beat that is not the last of its item is followed by another.
   a_bundle_continues: assert property (@(posedge clock) disable iff (reset)
      (pop && !empty && !rsp_data.last) |=> !empty)
      else $error("result bundle ended early");

   // Done and abort always close the results of their item.
   a_terminal_last: assert property (@(posedge clock) disable iff (reset)
      (!empty && (rsp_data.kind == xcrc_pkg::KIND_DONE ||
                  rsp_data.kind == xcrc_pkg::KIND_ABORT)) |-> rsp_data.last)
      else $error("done or abort not marked last");

   // A waiting beat holds until it is taken.
   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_data)))
      else $error("waiting result changed");

endmodule

bind xmodem_crc_sector_receiver_core xcrc_checker u_checker (
   .clock    (clock),
   .reset    (reset),
   .full     (full),
   .empty    (empty),
   .pop      (pop),
   .rsp_data (rsp_data)
);

/* tb/sv/testbench.sv */
// Self-checking testbench for the XMODEM-CRC sector receiver core.
module testbench;

   localparam int PurgeLimit  = 1000;
   localparam int DrainCycles = 20;
   localparam int HoldCycles  = 400;
   localparam int PhaseItems  = 40;
   localparam int FrameItems  = 134;

   // Operation code that the block must ignore.
   localparam logic [1:0] OP_SPARE = 2'd3;

   typedef enum logic [3:0] {
      RX_IDLE, RX_HEADER, RX_NUMBER, RX_COMPL, RX_DATA, RX_CRC_HI, RX_CRC_LO,
      RX_EOT_WAIT, RX_PURGE, RX_DONE, RX_ABORT
   } rx_phase_type;

   // Ways a generated sector is spoiled.
   typedef enum {FLT_NONE, FLT_COMPL, FLT_CRC, FLT_CUT} fault_type;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              csr_wr_en   = 1'b0;
   logic [3:0]        csr_wr_data = 4'd0;
   logic              push        = 1'b0;
   logic              full;
   xcrc_pkg::req_type req_data    = '0;
   logic              empty;
   logic              pop         = 1'b0;
   xcrc_pkg::rsp_type rsp_data;

   xmodem_crc_sector_receiver_core #(
      .PURGE_MAX(PurgeLimit)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .push       (push),
      .full       (full),
      .req_data   (req_data),
      .empty      (empty),
      .pop        (pop),
      .rsp_data   (rsp_data)
   );

   // Predicted receiver state and retry setting.
   rx_phase_type rx_phase;
   logic [7:0]   last_good_num;
   logic [7:0]   sector_num;
   logic [15:0]  crc_run;
   logic [10:0]  data_bytes;
   logic         long_sector;
   logic         no_good_yet;
   logic [3:0]   error_tally;
   logic         cancel_armed;
   logic [9:0]   purge_bytes;
   logic [3:0]   retry_cap;

   // Input beats waiting to be sent, and result beats waiting to arrive.
   xcrc_pkg::req_type line_items[$];
   xcrc_pkg::rsp_type awaited_beats[$];
   xcrc_pkg::rsp_type step_beats[$];

   int         gen_count  = 0;
   int         fail_count = 0;
   int         idle_odds  = 8;
   int         send_gap   = 0;
   int         pop_gap    = 0;
   int         hold_left  = 0;
   bit         calm       = 1'b0;
   bit         squeeze    = 1'b0;
   bit         hold_done  = 1'b0;
   logic [7:0] next_new   = 8'd1;

   initial begin
      forever #1 clock = ~clock;
   end

   // Bit-serial CRC-16, polynomial 0x1021, most significant bit first.
   function automatic logic [15:0] crc_update(input logic [15:0] c, input logic [7:0] d);
      logic fb;
      int   k;
      for (k = 7; k >= 0; k--) begin
         fb = c[15] ^ d[k];
         c  = {c[14:0], 1'b0};
         if (fb) begin
            c = c ^ 16'h1021;
         end
      end
      return c;
   endfunction

   // Adds a result beat for the current input; at most three per input.
   function automatic void note_beat(input logic [2:0] kind, input logic [7:0] value,
                                     input logic lng);
      xcrc_pkg::rsp_type r;
      if (step_beats.size() < xcrc_pkg::MaxResults) begin
         r.kind       = kind;
         r.value      = value;
         r.long_block = lng;
         r.last       = 1'b0;
         step_beats.push_back(r);
      end
   endfunction

   // Each error and each first cancel counts against the retry setting; zero acts as one.
   function automatic void tally_error();
      error_tally = error_tally + 4'd1;
      if (error_tally >= retry_cap || error_tally == 4'd0) begin
         note_beat(xcrc_pkg::KIND_ABORT, xcrc_pkg::CAUSE_RETRIES, 1'b0);
         rx_phase = RX_ABORT;
      end else begin
         rx_phase = RX_HEADER;
      end
   endfunction

   // The line is quiet again: ask for the sector with 'C' or NAK.
   function automatic void close_purge();
      note_beat(xcrc_pkg::KIND_TX, no_good_yet ? xcrc_pkg::CH_C : xcrc_pkg::CH_NAK, 1'b0);
      tally_error();
   endfunction

   // A sector error; a discard goes out only once the block number had passed.
   function automatic void sector_fault(input logic by_byte);
      if (rx_phase == RX_DATA || rx_phase == RX_CRC_HI || rx_phase == RX_CRC_LO) begin
         note_beat(xcrc_pkg::KIND_DISCARD, sector_num, 1'b0);
      end
      cancel_armed = 1'b0;
      purge_bytes  = '0;
      if (by_byte) begin
         rx_phase = RX_PURGE;
      end else begin
         close_purge();
      end
   endfunction

   // Works out the result beats of one accepted input beat and queues them.
   function automatic void receiver_step(input xcrc_pkg::req_type it);
      xcrc_pkg::rsp_type r;
      int                i;
      step_beats.delete();
      case (it.op)
         xcrc_pkg::OP_START: begin
            rx_phase      = RX_HEADER;
            last_good_num = '0;
            sector_num    = '0;
            crc_run       = '0;
            data_bytes    = '0;
            long_sector   = 1'b0;
            no_good_yet   = 1'b1;
            error_tally   = '0;
            cancel_armed  = 1'b0;
            purge_bytes   = '0;
            note_beat(xcrc_pkg::KIND_TX, xcrc_pkg::CH_C, 1'b0);
         end
         xcrc_pkg::OP_BYTE: begin
            case (rx_phase)
               RX_HEADER: begin
                  if (it.rx_byte == xcrc_pkg::CH_STX || it.rx_byte == xcrc_pkg::CH_SOH) begin
                     long_sector = (it.rx_byte == xcrc_pkg::CH_STX);
                     rx_phase    = RX_NUMBER;
                  end else if (it.rx_byte == xcrc_pkg::CH_EOT) begin
                     rx_phase = RX_EOT_WAIT;
                  end else if (it.rx_byte == xcrc_pkg::CH_CAN) begin
                     if (cancel_armed) begin
                        note_beat(xcrc_pkg::KIND_ABORT, xcrc_pkg::CAUSE_CANCEL, 1'b0);
                        rx_phase = RX_ABORT;
                     end else begin
                        cancel_armed = 1'b1;
                        tally_error();
                     end
                  end else begin
                     sector_fault(1'b1);
                  end
               end
               RX_NUMBER: begin
                  sector_num = it.rx_byte;
                  rx_phase   = RX_COMPL;
               end
               RX_COMPL: begin
                  if (9'(sector_num) + 9'(it.rx_byte) == xcrc_pkg::NUM_CHECK) begin
                     crc_run    = '0;
                     data_bytes = '0;
                     rx_phase   = RX_DATA;
                  end else begin
                     sector_fault(1'b1);
                  end
               end
               RX_DATA: begin
                  crc_run = crc_update(crc_run, it.rx_byte);
                  note_beat(xcrc_pkg::KIND_DATA, it.rx_byte, 1'b0);
                  data_bytes = data_bytes + 11'd1;
                  if (data_bytes >= (long_sector ? xcrc_pkg::LEN_LONG
                                                 : xcrc_pkg::LEN_SHORT)) begin
                     rx_phase = RX_CRC_HI;
                  end
               end
               RX_CRC_HI: begin
                  crc_run  = crc_update(crc_run, it.rx_byte);
                  rx_phase = RX_CRC_LO;
               end
               RX_CRC_LO: begin
                  crc_run = crc_update(crc_run, it.rx_byte);
                  if (crc_run != 16'h0000) begin
                     sector_fault(1'b1);
                  end else begin
                     // Good sector: new, repeated or out of sequence.
                     no_good_yet = 1'b0;
                     if (sector_num == 8'(last_good_num + 8'd1)) begin
                        last_good_num = sector_num;
                        note_beat(xcrc_pkg::KIND_COMMIT, sector_num, long_sector);
                        note_beat(xcrc_pkg::KIND_TX, xcrc_pkg::CH_ACK, 1'b0);
                     end else if (sector_num == last_good_num) begin
                        note_beat(xcrc_pkg::KIND_DISCARD, sector_num, 1'b0);
                        note_beat(xcrc_pkg::KIND_TX, xcrc_pkg::CH_ACK, 1'b0);
                     end else begin
                        note_beat(xcrc_pkg::KIND_DISCARD, sector_num, 1'b0);
                        note_beat(xcrc_pkg::KIND_ABORT, xcrc_pkg::CAUSE_SYNC, 1'b0);
                        rx_phase = RX_ABORT;
                     end
                     if (rx_phase != RX_ABORT) begin
                        error_tally  = '0;
                        cancel_armed = 1'b0;
                        rx_phase     = RX_HEADER;
                     end
                  end
               end
               RX_EOT_WAIT: begin
                  sector_fault(1'b1);
               end
               RX_PURGE: begin
                  purge_bytes = purge_bytes + 10'd1;
                  if (purge_bytes >= 10'(PurgeLimit) || purge_bytes == 10'd0) begin
                     close_purge();
                  end
               end
               default: begin
               end
            endcase
         end
         xcrc_pkg::OP_TIMEOUT: begin
            case (rx_phase)
               RX_HEADER, RX_NUMBER, RX_COMPL, RX_DATA, RX_CRC_HI, RX_CRC_LO: begin
                  sector_fault(1'b0);
               end
               RX_EOT_WAIT: begin
                  note_beat(xcrc_pkg::KIND_TX, xcrc_pkg::CH_ACK, 1'b0);
                  note_beat(xcrc_pkg::KIND_DONE, 8'd0, 1'b0);
                  rx_phase = RX_DONE;
               end
               RX_PURGE: begin
                  close_purge();
               end
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase
      for (i = 0; i < step_beats.size(); i++) begin
         r      = step_beats[i];
         r.last = (i == step_beats.size() - 1);
         awaited_beats.push_back(r);
      end
   endfunction

   function automatic void queue_item(input logic [1:0] op, input logic [7:0] b);
      xcrc_pkg::req_type it;
      it.op      = op;
      it.rx_byte = b;
      line_items.push_back(it);
      gen_count++;
   endfunction

   // A start beat; the first new sector after it is number one.
   function automatic void restart_session();
      queue_item(xcrc_pkg::OP_START, 8'($urandom));
      next_new = 8'd1;
   endfunction

   // Frames one sector with random data; a fault spoils it, and a timeout follows.
   function automatic void queue_sector(input logic lng, input logic [7:0] num,
                                        input fault_type flt);
      logic [7:0]  frame[$];
      logic [15:0] sum;
      int          len;
      int          cut;
      int          pos;
      int          i;
      sum = '0;
      len = lng ? 1024 : 128;
      frame.push_back(lng ? xcrc_pkg::CH_STX : xcrc_pkg::CH_SOH);
      frame.push_back(num);
      frame.push_back(flt == FLT_COMPL ? (~num ^ (8'h01 << $urandom_range(0, 7))) : ~num);
      for (i = 0; i < len; i++) begin
         frame.push_back(8'($urandom));
         sum = crc_update(sum, frame[frame.size() - 1]);
      end
      frame.push_back(sum[15:8]);
      frame.push_back(sum[7:0]);
      // A single flipped bit in data or check bytes always breaks the CRC.
      if (flt == FLT_CRC) begin
         pos        = $urandom_range(3, frame.size() - 1);
         frame[pos] = frame[pos] ^ (8'h01 << $urandom_range(0, 7));
      end
      cut = frame.size();
      if (flt == FLT_COMPL) begin
         cut = 3 + $urandom_range(0, 4);
      end else if (flt == FLT_CUT) begin
         if (lng) begin
            cut = $urandom_range(0, frame.size() - 1);
         end else begin
            cut = $urandom_range(0, 12);
         end
      end
      for (i = 0; i < cut; i++) begin
         queue_item(xcrc_pkg::OP_BYTE, frame[i]);
      end
      if (flt != FLT_NONE) begin
         queue_item(xcrc_pkg::OP_TIMEOUT, 8'($urandom));
      end
   endfunction

   task automatic flag_mismatch(input string msg);
      fail_count++;
      $display("mismatch at %0t: %s", $time, msg);
   endtask

   // Waits until every beat has been sent and answered, then lets the block go quiet.
   task automatic settle();
      while (line_items.size() != 0 || push || awaited_beats.size() != 0) begin
         @(posedge clock);
      end
      repeat (DrainCycles) @(posedge clock);
   endtask

   // Input side: offers queued beats with random gaps and predicts each accepted beat.
   always @(posedge clock) begin
      if (reset) begin
         push <= 1'b0;
      end else begin
         if (push && !full) begin
            receiver_step(req_data);
         end
         if (push && full) begin
            // The block is full: the same beat stays on offer.
         end else if (send_gap != 0) begin
            send_gap--;
            push <= 1'b0;
         end else if (line_items.size() != 0 && !calm && $urandom_range(0, idle_odds) == 0) begin
            send_gap = $urandom_range(0, 11);
            push <= 1'b0;
         end else if (line_items.size() != 0) begin
            req_data <= line_items.pop_front();
            push     <= 1'b1;
         end else begin
            push <= 1'b0;
         end
      end
   end

   // Result side: checks each accepted beat against the oldest prediction.
   always @(posedge clock) begin : result_side
      xcrc_pkg::rsp_type want;
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            if (awaited_beats.size() == 0) begin
               flag_mismatch($sformatf("beat with nothing awaited: kind %0d value 0x%02h",
                                       rsp_data.kind, rsp_data.value));
            end else begin
               want = awaited_beats.pop_front();
               if (rsp_data.kind !== want.kind) begin
                  flag_mismatch($sformatf("kind %0d, predicted %0d", rsp_data.kind, want.kind));
               end
               if (rsp_data.value !== want.value) begin
                  flag_mismatch($sformatf("value 0x%02h, predicted 0x%02h (kind %0d)",
                                          rsp_data.value, want.value, want.kind));
               end
               if (rsp_data.long_block !== want.long_block) begin
                  flag_mismatch($sformatf("long_block %0b, predicted %0b",
                                          rsp_data.long_block, want.long_block));
               end
               if (rsp_data.last !== want.last) begin
                  flag_mismatch($sformatf("last %0b, predicted %0b (kind %0d)",
                                          rsp_data.last, want.last, want.kind));
               end
            end
         end
         // One long hold-off fills the block so that it stalls its input.
         if (hold_left != 0) begin
            hold_left--;
            pop <= 1'b0;
         end else if (squeeze && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HoldCycles;
            pop <= 1'b0;
         end else if (pop_gap != 0) begin
            pop_gap--;
            pop <= 1'b0;
         end else if (!calm && $urandom_range(0, idle_odds) == 0) begin
            pop_gap = $urandom_range(0, 11);
            pop <= 1'b0;
         end else begin
            pop <= 1'b1;
         end
      end
   end

   initial begin
      #200000;
      $display("testbench: FAIL");
      $finish;
   end

   // Stimulus: a directed opening, then phases at several retry settings.
   initial begin
      logic [3:0] caps[5];
      logic [3:0] cap;
      int         ph;
      int         stop_at;
      int         room;
      int         pick;
      int         n;
      int         k;
      caps          = '{4'd1, 4'd15, 4'd4, 4'd0, 4'd15};
      rx_phase      = RX_IDLE;
      last_good_num = '0;
      sector_num    = '0;
      crc_run       = '0;
      data_bytes    = '0;
      long_sector   = 1'b0;
      no_good_yet   = 1'b1;
      error_tally   = '0;
      cancel_armed  = 1'b0;
      purge_bytes   = '0;
      retry_cap     = xcrc_pkg::RETRY_LIMIT_RESET;

      // Bytes and timeouts before any start are ignored.
      queue_item(xcrc_pkg::OP_BYTE, 8'h00);
      queue_item(xcrc_pkg::OP_TIMEOUT, 8'hFF);
      // Start; the unused operation is ignored; a timeout at the header asks again.
      restart_session();
      queue_item(OP_SPARE, 8'hA5);
      queue_item(xcrc_pkg::OP_TIMEOUT, 8'h00);
      // A stray byte starts a purge that the next timeout ends.
      queue_item(xcrc_pkg::OP_BYTE, 8'hFF);
      queue_item(xcrc_pkg::OP_TIMEOUT, 8'h5A);
      // Two cancels in a row abort the session.
      queue_item(xcrc_pkg::OP_BYTE, xcrc_pkg::CH_CAN);
      queue_item(xcrc_pkg::OP_BYTE, xcrc_pkg::CH_CAN);
      // A block number with a wrong complement.
      restart_session();
      queue_item(xcrc_pkg::OP_BYTE, xcrc_pkg::CH_SOH);
      queue_item(xcrc_pkg::OP_BYTE, 8'h01);
      queue_item(xcrc_pkg::OP_BYTE, 8'h00);
      queue_item(xcrc_pkg::OP_TIMEOUT, 8'h00);
      // A long sector cut off in its data: the received number is discarded.
      queue_item(xcrc_pkg::OP_BYTE, xcrc_pkg::CH_STX);
      queue_item(xcrc_pkg::OP_BYTE, 8'hFF);
      queue_item(xcrc_pkg::OP_BYTE, 8'h00);
      queue_item(xcrc_pkg::OP_BYTE, 8'h5A);
      queue_item(xcrc_pkg::OP_TIMEOUT, 8'hFF);
      // A byte after EOT is an error; EOT followed by silence completes the transfer.
      queue_item(xcrc_pkg::OP_BYTE, xcrc_pkg::CH_EOT);
      queue_item(xcrc_pkg::OP_BYTE, 8'h33);
      queue_item(xcrc_pkg::OP_TIMEOUT, 8'h00);
      queue_item(xcrc_pkg::OP_BYTE, xcrc_pkg::CH_EOT);
      queue_item(xcrc_pkg::OP_TIMEOUT, 8'h00);
      // Once done, bytes are ignored.
      queue_item(xcrc_pkg::OP_BYTE, 8'h12);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      for (ph = 0; ph < 5; ph++) begin
         settle();
         cap       = (ph == 2) ? 4'($urandom_range(2, 14)) : caps[ph];
         idle_odds = (ph % 3 == 0) ? 3 : (ph % 3 == 1) ? 10 : 60;
         @(posedge clock);
         csr_wr_en   <= 1'b1;
         csr_wr_data <= cap;
         @(posedge clock);
         csr_wr_en   <= 1'b0;
         retry_cap   = cap;
         calm        = (ph == 4);
         restart_session();
         stop_at = gen_count + PhaseItems;

         if (ph == 1) begin
            // A good short sector while the result side holds off for a long stretch.
            squeeze = 1'b1;
            queue_sector(1'b0, next_new, FLT_NONE);
            next_new++;
         end

         // Good and broken sectors, line noise; whole frames only where the budget allows.
         while (gen_count < stop_at) begin
            room = stop_at - gen_count;
            if (room >= FrameItems) begin
               pick = $urandom_range(0, 99);
            end else begin
               pick = $urandom_range(40, 99);
            end
            if (pick < 30) begin
               queue_sector(1'b0, next_new, FLT_NONE);
               next_new++;
            end else if (pick < 36) begin
               queue_sector(1'b0, next_new - 8'd1, FLT_NONE);
            end else if (pick < 40) begin
               // Out of sequence: neither the next nor the repeated number.
               queue_sector(1'b0, next_new + 8'($urandom_range(1, 254)), FLT_NONE);
               restart_session();
            end else if (pick < 75) begin
               if (pick < 55) begin
                  queue_sector(1'b0, next_new, FLT_CUT);
               end else if (pick < 62) begin
                  queue_sector(1'b0, next_new, FLT_COMPL);
               end else if (pick < 69 && room >= FrameItems) begin
                  queue_sector(1'b0, next_new, FLT_CRC);
               end else begin
                  n = $urandom_range(1, 5);
                  repeat (n) queue_item(xcrc_pkg::OP_BYTE, 8'($urandom));
                  queue_item(xcrc_pkg::OP_TIMEOUT, 8'($urandom));
               end
               if ($urandom_range(1, 8) > retry_cap) begin
                  restart_session();
               end
            end else if (pick < 80) begin
               queue_item(xcrc_pkg::OP_BYTE, xcrc_pkg::CH_CAN);
               if ($urandom_range(0, 1) == 0) begin
                  queue_item(xcrc_pkg::OP_BYTE, xcrc_pkg::CH_CAN);
                  restart_session();
               end
            end else if (pick < 85) begin
               queue_item(xcrc_pkg::OP_BYTE, xcrc_pkg::CH_EOT);
               if ($urandom_range(0, 1) == 0) begin
                  queue_item(xcrc_pkg::OP_TIMEOUT, 8'($urandom));
                  restart_session();
               end else begin
                  queue_item(xcrc_pkg::OP_BYTE, 8'($urandom));
                  queue_item(xcrc_pkg::OP_TIMEOUT, 8'($urandom));
               end
            end else if (pick < 90) begin
               n = $urandom_range(1, 4);
               repeat (n) begin
                  k = $urandom_range(0, 2);
                  queue_item(k == 0 ? xcrc_pkg::OP_BYTE
                                    : (k == 1 ? xcrc_pkg::OP_TIMEOUT : OP_SPARE),
                             8'($urandom));
               end
            end else if (pick < 95) begin
               restart_session();
            end else begin
               queue_item(xcrc_pkg::OP_TIMEOUT, 8'($urandom));
            end
         end
      end

      settle();
      if (fail_count == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule
